/* rtl/core/nlm_pkg.sv */
package nlm_pkg;

    // node liveness codes
    localparam logic [1:0] ST_UNKNOWN = 2'd0;
    localparam logic [1:0] ST_ALIVE   = 2'd1;
    localparam logic [1:0] ST_SUSPECT = 2'd2;
    localparam logic [1:0] ST_DEAD    = 2'd3;

    // event codes
    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_DISCOVERED = 3'd1;
    localparam logic [2:0] EV_RECOVERED  = 3'd2;
    localparam logic [2:0] EV_SUSPECT    = 3'd3;
    localparam logic [2:0] EV_DEAD       = 3'd4;

    // request actions
    localparam logic [1:0] ACT_HEARTBEAT = 2'd0;
    localparam logic [1:0] ACT_TICK      = 2'd1;
    localparam logic [1:0] ACT_STATUS    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_MY_NODE_ID   = 2'd0;
    localparam logic [1:0] REG_SUSPECT_THR  = 2'd1;
    localparam logic [1:0] REG_DEAD_THR     = 2'd2;

    localparam logic [7:0] DEFAULT_THRESHOLD = 8'd6;
    localparam logic [7:0] COUNT_MAX         = 8'hFF;
    localparam logic [4:0] MAX_RESULTS       = 5'd16;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] node;
    } req_word_t;

    typedef struct packed {
        logic [3:0] node_index;
        logic [1:0] node_status;
        logic [7:0] missed_count;
        logic [2:0] event_res;
        logic       last;
    } rsp_word_t;

    typedef struct packed {
        logic [1:0] node_status;
        logic [7:0] missed_count;
    } entry_t;

endpackage

/* rtl/core/node_liveness_monitor_unit.sv */
// node liveness monitor: keeps a liveness state and missed-tick count per node
//
// req channel (req_valid, req_stall, req_word): one word is a heartbeat from
// a node, an aging tick or a status read. req_stall is high while a word is
// being worked on. rsp channel (rsp_valid, rsp_stall, rsp_word): results,
// last marks the final result of a request word; a tick that moves no node
// gives no result, an unused action gives none either.
// cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data): cfg_ready is always
// high; index 0 own node id, 1 suspect threshold, 2 dead threshold.
// timing: heartbeat and status read pass the read and execute states before
// the result is registered; a tick walks the node table one entry at a time,
// a read state then an update state for each, set by the single table port
// and the one increment/compare unit. The output register frees the request
// side, so a new word is taken while a result still waits on rsp_stall; a
// stalled result holds the walk only when a further result must be pushed.
// reset: every node unknown with count 0, own id 0, both thresholds 6.
module node_liveness_monitor_unit #(
    parameter int NODES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  nlm_pkg::req_word_t  req_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output nlm_pkg::rsp_word_t  rsp_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    localparam int IW = $clog2(NODES);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [IW-1:0]     addr_reg, addr_next;
    logic [1:0]        op_reg, op_next;
    logic [3:0]        node_reg, node_next;
    logic              in_range_reg, in_range_next;
    logic [4:0]        res_cnt_reg, res_cnt_next;
    logic              pend_valid_reg, pend_valid_next;
    nlm_pkg::rsp_word_t pend_reg, pend_next;
    logic              rsp_valid_reg, rsp_valid_next;
    nlm_pkg::rsp_word_t rsp_word_reg, rsp_word_next;

    logic [3:0]        my_id_reg;
    logic [7:0]        susp_thr_reg;
    logic [7:0]        dead_thr_reg;

    nlm_pkg::entry_t   rd_entry;
    nlm_pkg::entry_t   wr_entry;
    logic              tbl_we;

    logic              out_free;
    logic              is_self;
    logic              eligible;
    logic [7:0]        cnt_inc;
    logic [7:0]        thr;
    logic              trans;
    logic              report;
    logic              last_node;
    logic              req_in_range;

    nlm_table #(
        .NODES(NODES)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .addr    (addr_reg),
        .we      (tbl_we),
        .wr_data (wr_entry),
        .rd_data (rd_entry)
    );

    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    assign req_in_range = (32'(req_word.node) < NODES);
    assign last_node    = (addr_reg == IW'(NODES - 1));

    // shared age unit: saturating increment and threshold compare
    always_comb
    begin
        is_self  = (32'(addr_reg) == 32'(my_id_reg));
        eligible = !is_self && ((rd_entry.node_status == nlm_pkg::ST_ALIVE) ||
                                (rd_entry.node_status == nlm_pkg::ST_SUSPECT));
        cnt_inc  = (rd_entry.missed_count == nlm_pkg::COUNT_MAX) ?
                   rd_entry.missed_count : rd_entry.missed_count + 8'd1;
        thr      = (rd_entry.node_status == nlm_pkg::ST_ALIVE) ?
                   susp_thr_reg : dead_thr_reg;
        trans    = eligible && (cnt_inc >= thr);
        report   = trans && (res_cnt_reg < nlm_pkg::MAX_RESULTS);
    end

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        op_next         = op_reg;
        node_next       = node_reg;
        in_range_next   = in_range_reg;
        res_cnt_next    = res_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_word_next   = rsp_word_reg;
        tbl_we          = 1'b0;
        wr_entry        = rd_entry;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next         = req_word.action;
                    node_next       = req_word.node;
                    in_range_next   = req_in_range;
                    res_cnt_next    = '0;
                    pend_valid_next = 1'b0;
                    if (req_word.action == nlm_pkg::ACT_TICK)
                    begin
                        addr_next  = '0;
                        state_next = S_READ;
                    end
                    else if (req_word.action == nlm_pkg::ACT_HEARTBEAT ||
                             req_word.action == nlm_pkg::ACT_STATUS)
                    begin
                        addr_next  = req_in_range ? IW'(req_word.node) : '0;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (op_reg == nlm_pkg::ACT_TICK)
                begin
                    if (trans)
                    begin
                        wr_entry.node_status  = (rd_entry.node_status == nlm_pkg::ST_ALIVE) ?
                                                nlm_pkg::ST_SUSPECT : nlm_pkg::ST_DEAD;
                        wr_entry.missed_count = '0;
                    end
                    else
                    begin
                        wr_entry.missed_count = cnt_inc;
                    end
                    // a new result pushes the held one out, so that one is not last
                    if (!(report && pend_valid_reg) || out_free)
                    begin
                        tbl_we = eligible;
                        if (report)
                        begin
                            if (pend_valid_reg)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_word_next  = pend_reg;
                            end
                            pend_valid_next        = 1'b1;
                            pend_next.node_index   = 4'(addr_reg);
                            pend_next.node_status  = wr_entry.node_status;
                            pend_next.missed_count = '0;
                            pend_next.event_res    =
                                (rd_entry.node_status == nlm_pkg::ST_ALIVE) ?
                                nlm_pkg::EV_SUSPECT : nlm_pkg::EV_DEAD;
                            pend_next.last         = 1'b0;
                            res_cnt_next           = res_cnt_reg + 5'd1;
                        end
                        if (last_node)
                        begin
                            state_next = S_FLUSH;
                        end
                        else
                        begin
                            addr_next  = addr_reg + IW'(1);
                            state_next = S_READ;
                        end
                    end
                end
                else if (out_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_word_next.node_index  = node_reg;
                    rsp_word_next.last        = 1'b1;
                    rsp_word_next.event_res   = nlm_pkg::EV_NONE;
                    if (!in_range_reg)
                    begin
                        rsp_word_next.node_status  = nlm_pkg::ST_UNKNOWN;
                        rsp_word_next.missed_count = '0;
                    end
                    else if (op_reg == nlm_pkg::ACT_HEARTBEAT && node_reg != my_id_reg)
                    begin
                        tbl_we                     = 1'b1;
                        wr_entry.node_status       = nlm_pkg::ST_ALIVE;
                        wr_entry.missed_count      = '0;
                        rsp_word_next.node_status  = nlm_pkg::ST_ALIVE;
                        rsp_word_next.missed_count = '0;
                        if (rd_entry.node_status == nlm_pkg::ST_UNKNOWN)
                        begin
                            rsp_word_next.event_res = nlm_pkg::EV_DISCOVERED;
                        end
                        else if (rd_entry.node_status != nlm_pkg::ST_ALIVE)
                        begin
                            rsp_word_next.event_res = nlm_pkg::EV_RECOVERED;
                        end
                    end
                    else
                    begin
                        rsp_word_next.node_status  = rd_entry.node_status;
                        rsp_word_next.missed_count = rd_entry.missed_count;
                    end
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_word_next      = pend_reg;
                    rsp_word_next.last = 1'b1;
                    pend_valid_next    = 1'b0;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            my_id_reg      <= '0;
            susp_thr_reg   <= nlm_pkg::DEFAULT_THRESHOLD;
            dead_thr_reg   <= nlm_pkg::DEFAULT_THRESHOLD;
        end
        else
        begin
            state_reg      <= state_next;
            res_cnt_reg    <= res_cnt_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    nlm_pkg::REG_MY_NODE_ID:  my_id_reg    <= cfg_data[3:0];
                    nlm_pkg::REG_SUSPECT_THR: susp_thr_reg <= cfg_data;
                    nlm_pkg::REG_DEAD_THR:    dead_thr_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        op_reg       <= op_next;
        node_reg     <= node_next;
        in_range_reg <= in_range_next;
        pend_reg     <= pend_next;
        rsp_word_reg <= rsp_word_next;
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("held result left over after a walk");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= nlm_pkg::MAX_RESULTS)
        else $error("result count beyond its cap");

    assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> (state_reg == S_EXEC))
        else $error("table written outside the update cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_EXEC || $past(state_reg) == S_FLUSH))
        else $error("result appeared without an update or flush");
`endif

endmodule

/* rtl/core/nlm_table.sv */
module nlm_table #(
    parameter int NODES = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [$clog2(NODES)-1:0]  addr,
    input  logic                      we,
    input  nlm_pkg::entry_t           wr_data,
    output nlm_pkg::entry_t           rd_data
);

    nlm_pkg::entry_t entry_mem [NODES];
    nlm_pkg::entry_t rd_data_reg;
    logic [NODES-1:0] valid_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_mem[addr] <= wr_data;
        end
        rd_data_reg <= entry_mem[addr];
    end

    // an entry never written reads as unknown with a zero count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : nlm_pkg::entry_t'('0);

endmodule
